>>> hdl/sndp_pkg.sv
// ----------------------------------------------------------------------------
// sndp_pkg
// Shared types and constants of the sigmoid neuron dot product unit.
// ----------------------------------------------------------------------------
package sndp_pkg;

	// field widths
	localparam int DATA_W        = 16;
	localparam int PROD_W        = 2 * DATA_W;
	localparam int ACC_WIDTH_DEF = 40;
	localparam int NCNT_W        = 9;
	localparam int IDX_W         = 8;
	localparam int Y_W           = 16;
	localparam int D_W           = 15;
	localparam int CFG_IDX_W     = 2;
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 40;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIAS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NCOUNT = CFG_IDX_W'(1);

	// register reset values
	localparam logic signed [DATA_W-1:0] BIAS_RESET   = 16'sd4096;
	localparam logic [NCNT_W-1:0]        NCOUNT_RESET = 9'd10;
	localparam logic [NCNT_W-1:0]        NCOUNT_MAX   = 9'd256;

	// sigmoid breakpoints on |sum| with 24 fraction bits
	localparam logic [63:0] SIG_SAT   = 64'd83886080;  // 5.0
	localparam logic [63:0] SIG_KNEE  = 64'd39845888;  // 2.375
	localparam logic [63:0] SIG_ONE   = 64'd16777216;  // 1.0
	localparam int          SH_HI     = 13;
	localparam int          SH_MID    = 11;
	localparam int          SH_LO     = 10;
	localparam logic [16:0] OFS_HI    = 17'd55296;
	localparam logic [16:0] OFS_MID   = 17'd40960;
	localparam logic [16:0] OFS_LO    = 17'd32768;
	localparam logic [16:0] SIG_FULL  = 17'd65536;
	localparam logic [16:0] SIG_TOP   = 17'd65535;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ACC,
		ST_SIG,
		ST_DER
	} state_t;

	typedef struct packed {
		logic load_op;
		logic do_mul;
		logic do_acc;
		logic do_sig;
		logic do_out;
	} cmd_t;

endpackage

>>> hdl/sndp_ctrl.sv
// ----------------------------------------------------------------------------
// sndp_ctrl
// Sequencer: steps each request through multiply, accumulate and, on the
// last term, sigmoid and derivative, and owns the result valid flag.
// ----------------------------------------------------------------------------
module sndp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	output logic           s_ready,
	input  logic           s_last,
	output logic           m_valid,
	input  logic           m_ready,
	output sndp_pkg::cmd_t cmd
);

	sndp_pkg::state_t state_q, state_d;
	logic             last_q;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || m_ready;
	assign m_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sndp_pkg::ST_IDLE;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_op) begin
				last_q <= s_last;
			end
			if (cmd.do_out) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		s_ready = 1'b0;
		unique case (state_q)
			sndp_pkg::ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.load_op = 1'b1;
					state_d     = sndp_pkg::ST_MUL;
				end
			end
			sndp_pkg::ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = sndp_pkg::ST_ACC;
			end
			sndp_pkg::ST_ACC: begin
				cmd.do_acc = 1'b1;
				state_d    = last_q ? sndp_pkg::ST_SIG : sndp_pkg::ST_IDLE;
			end
			sndp_pkg::ST_SIG: begin
				cmd.do_sig = 1'b1;
				state_d    = sndp_pkg::ST_DER;
			end
			sndp_pkg::ST_DER: begin
				// wait until the output register can take the result
				if (out_free) begin
					cmd.do_out = 1'b1;
					state_d    = sndp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sndp_pkg::ST_IDLE;
			end
		endcase
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.do_out && out_valid_q && !m_ready))
		else $error("pending result overwritten");

	a_out_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_out |=> out_valid_q)
		else $error("result not presented after load");

	a_term_sequence: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_op |=> cmd.do_mul ##1 cmd.do_acc)
		else $error("term did not pass multiply then accumulate");

	a_sig_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_sig |-> last_q)
		else $error("sigmoid started on a term that is not last");

endmodule

>>> hdl/sndp_datapath.sv
// ----------------------------------------------------------------------------
// sndp_datapath
// Configuration registers, multiplier, saturating accumulator, piecewise
// linear sigmoid, derivative multiplier, neuron counter and result register.
// ----------------------------------------------------------------------------
module sndp_datapath #(
	parameter int ACC_WIDTH = sndp_pkg::ACC_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sndp_pkg::cmd_t                       cmd,
	input  logic                                 cfg_we,
	input  logic [sndp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sndp_pkg::DATA_W-1:0]          cfg_data,
	input  logic signed [sndp_pkg::DATA_W-1:0]   weight,
	input  logic signed [sndp_pkg::DATA_W-1:0]   activation,
	input  logic                                 use_bias,
	output logic [sndp_pkg::IDX_W-1:0]           neuron_index,
	output logic [sndp_pkg::Y_W-1:0]             activation_out,
	output logic [sndp_pkg::D_W-1:0]             derivative,
	output logic                                 layer_done
);

	localparam int SUM_W = ((ACC_WIDTH > sndp_pkg::PROD_W) ? ACC_WIDTH : sndp_pkg::PROD_W) + 1;

	logic signed [sndp_pkg::DATA_W-1:0] bias_q;
	logic [sndp_pkg::NCNT_W-1:0]        ncount_q;
	logic signed [sndp_pkg::DATA_W-1:0] weight_q;
	logic signed [sndp_pkg::DATA_W-1:0] mult_q;
	logic signed [sndp_pkg::PROD_W-1:0] prod_q;
	logic signed [ACC_WIDTH-1:0]        acc_q;
	logic [sndp_pkg::IDX_W-1:0]         neuron_q;
	logic [sndp_pkg::Y_W-1:0]           y_q;
	logic [sndp_pkg::IDX_W-1:0]         out_index_q;
	logic [sndp_pkg::Y_W-1:0]           out_y_q;
	logic [sndp_pkg::D_W-1:0]           out_d_q;
	logic                               out_done_q;

	logic [SUM_W-1:0]                   sum;
	logic                               sum_fits;
	logic [ACC_WIDTH-1:0]               acc_next;
	logic                               neg;
	logic [ACC_WIDTH-1:0]               mag;
	logic [63:0]                        mag64;
	logic [16:0]                        y_pos;
	logic [16:0]                        y_signed;
	logic [sndp_pkg::Y_W-1:0]           y_sat;
	logic [32:0]                        dprod;
	logic [sndp_pkg::NCNT_W-1:0]        nxt;
	logic [sndp_pkg::NCNT_W-1:0]        cnt_eff;
	logic                               done;

	// saturating accumulate, exact in one extra bit
	always_comb begin
		sum = {{(SUM_W - ACC_WIDTH){acc_q[ACC_WIDTH-1]}}, acc_q}
			+ {{(SUM_W - sndp_pkg::PROD_W){prod_q[sndp_pkg::PROD_W-1]}}, prod_q};
		sum_fits = (&sum[SUM_W-1:ACC_WIDTH-1]) || !(|sum[SUM_W-1:ACC_WIDTH-1]);
		if (sum_fits) begin
			acc_next = sum[ACC_WIDTH-1:0];
		end else if (sum[SUM_W-1]) begin
			acc_next = {1'b1, {(ACC_WIDTH - 1){1'b0}}};
		end else begin
			acc_next = {1'b0, {(ACC_WIDTH - 1){1'b1}}};
		end
	end

	// piecewise linear sigmoid on |sum|, mirrored for negative sums
	always_comb begin
		neg   = acc_q[ACC_WIDTH-1];
		mag   = neg ? (~acc_q + ACC_WIDTH'(1)) : acc_q;
		mag64 = 64'(mag);
		priority if (mag64 >= sndp_pkg::SIG_SAT) begin
			y_pos = sndp_pkg::SIG_FULL;
		end else if (mag64 >= sndp_pkg::SIG_KNEE) begin
			y_pos = 17'(mag64 >> sndp_pkg::SH_HI) + sndp_pkg::OFS_HI;
		end else if (mag64 >= sndp_pkg::SIG_ONE) begin
			y_pos = 17'(mag64 >> sndp_pkg::SH_MID) + sndp_pkg::OFS_MID;
		end else begin
			y_pos = 17'(mag64 >> sndp_pkg::SH_LO) + sndp_pkg::OFS_LO;
		end
		y_signed = neg ? (sndp_pkg::SIG_FULL - y_pos) : y_pos;
		y_sat    = (y_signed > sndp_pkg::SIG_TOP) ? sndp_pkg::Y_W'(sndp_pkg::SIG_TOP)
			: y_signed[sndp_pkg::Y_W-1:0];
	end

	// out * (1 - out), keep bits above the 16 fraction bits
	assign dprod = 33'(y_q) * 33'(sndp_pkg::SIG_FULL - 17'(y_q));

	always_comb begin
		nxt     = sndp_pkg::NCNT_W'(neuron_q) + sndp_pkg::NCNT_W'(1);
		cnt_eff = (ncount_q == '0 || ncount_q > sndp_pkg::NCOUNT_MAX)
			? sndp_pkg::NCOUNT_MAX : ncount_q;
		done    = (nxt >= cnt_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q   <= sndp_pkg::BIAS_RESET;
			ncount_q <= sndp_pkg::NCOUNT_RESET;
			acc_q    <= '0;
			neuron_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sndp_pkg::REG_BIAS:   bias_q   <= cfg_data;
					sndp_pkg::REG_NCOUNT: ncount_q <= cfg_data[sndp_pkg::NCNT_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.do_acc) begin
				acc_q <= acc_next;
			end else if (cmd.do_out) begin
				acc_q    <= '0;
				neuron_q <= done ? '0 : nxt[sndp_pkg::IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			weight_q <= weight;
			mult_q   <= use_bias ? bias_q : activation;
		end
		if (cmd.do_mul) begin
			prod_q <= weight_q * mult_q;
		end
		if (cmd.do_sig) begin
			y_q <= y_sat;
		end
		if (cmd.do_out) begin
			out_index_q <= neuron_q;
			out_y_q     <= y_q;
			out_d_q     <= dprod[16 +: sndp_pkg::D_W];
			out_done_q  <= done;
		end
	end

	assign neuron_index   = out_index_q;
	assign activation_out = out_y_q;
	assign derivative     = out_d_q;
	assign layer_done     = out_done_q;

endmodule

>>> hdl/sigmoid_neuron_dot_product_unit.sv
// ----------------------------------------------------------------------------
// sigmoid_neuron_dot_product_unit
// Fully connected layer neuron: saturating multiply-accumulate of Q4.12
// terms, piecewise linear sigmoid in Q0.16 and its derivative per neuron.
// ----------------------------------------------------------------------------
// Each term passes operand capture, one 16x16 multiply and one saturating add
// before the next term can be accepted, and the term marked tlast also passes
// sigmoid and derivative multiply, and waits further only while the previous
// result still waits in the output register. The shared multiply and
// accumulate sequence handles one term at a time. A result leaves
// on the master side with tlast set when that neuron is the last of the
// layer; the neuron index wraps after neuron_count results. Registers:
// index 0 bias_value (signed Q4.12, reset 1.0), index 1 neuron_count
// (0 or above 256 means 256, reset 10); write them while the unit is idle.
module sigmoid_neuron_dot_product_unit #(
	parameter int ACC_WIDTH = sndp_pkg::ACC_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// weight [15:0], activation [31:16]
	input  logic [sndp_pkg::IN_TDATA_W-1:0]        s_axis_tdata,
	// use_bias [0]
	input  logic [0:0]                             s_axis_tuser,
	// last_term
	input  logic                                   s_axis_tlast,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// neuron_index [7:0], activation_out [23:8], derivative [38:24], zero [39]
	output logic [sndp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// layer_done
	output logic                                   m_axis_tlast,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [sndp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [sndp_pkg::DATA_W-1:0]            cfg_data
);

	sndp_pkg::cmd_t                  cmd;
	logic [sndp_pkg::IDX_W-1:0]      neuron_index;
	logic [sndp_pkg::Y_W-1:0]        activation_out;
	logic [sndp_pkg::D_W-1:0]        derivative;

	assign cfg_ready = 1'b1;

	sndp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_last  (s_axis_tlast),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd)
	);

	sndp_datapath #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.weight         (s_axis_tdata[sndp_pkg::DATA_W-1:0]),
		.activation     (s_axis_tdata[2*sndp_pkg::DATA_W-1:sndp_pkg::DATA_W]),
		.use_bias       (s_axis_tuser[0]),
		.neuron_index   (neuron_index),
		.activation_out (activation_out),
		.derivative     (derivative),
		.layer_done     (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, derivative, activation_out, neuron_index};

endmodule
